// ===== rtl/core/tce_pkg.sv =====
// Shared constants and helpers for the transitive closure engine.
package tce_pkg;

  localparam int unsigned ROW_W           = 32;
  localparam int unsigned CFG_W           = 6;
  localparam int unsigned DEF_MAX_NODES   = 32;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 6'd32;

  // Keep columns below n, clear the rest.
  function automatic logic [ROW_W-1:0] col_mask(input logic [CFG_W-1:0] n);
    logic [ROW_W-1:0] m;
    m = '0;
    for (int j = 0; j < ROW_W; j++) begin
      m[j] = (CFG_W'(j) < n);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/tce_mem.sv =====
// Row memory of the reachability matrix: one write port, one registered read port.
module tce_mem import tce_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_NODES
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ROW_W-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ROW_W-1:0]         rdata_o
);

  logic [ROW_W-1:0] mem_q [DEPTH];
  logic [ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/transitive_closure_engine.sv =====
// Top level: row loader, Warshall sequencer and closure row emitter.
//
// Usage: load node_count adjacency rows, row 0 first, on the slave stream
// (one item per row, bit j set = edge to node j). The item that completes
// the graph starts the closure; s_axis_tready_o stays low from then until
// the last closure row has been taken. Closure rows leave on the master
// stream from row 0 upward, row index in tdata[36:32], tlast on the last
// row. node_count (cfg port) is clamped to 1..min(MAX_NODES, 32) and must
// only be written while the block is idle.
// Sequence for n active nodes: loading stores one row per cycle. The closure
// walks the row memory once per pivot row k: it reads the pivot (S_PIV),
// captures it (S_PCAP), then does a read-modify-write of each of the n rows
// (S_SCAN), paced by the single read and single write port of the row
// memory. Each closure row is then read (S_ERD) and presented (S_EOUT)
// until the receiver takes it; the row is held stable meanwhile.
// Reset: empty load, node_count = 32; matrix contents are not cleared.
module transitive_closure_engine import tce_pkg::*; #(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,     // node_count
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [31:0]      s_axis_tdata_i,  // [31:0] adjacency_row
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,  // [31:0] closure_row, [36:32] row_number
  output logic             m_axis_tlast_o   // final_row
);

  localparam int unsigned LIM    = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int unsigned ADDR_W = $clog2(LIM);
  localparam int unsigned CNT_W  = $clog2(LIM + 1);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_PIV  = 6'b000010,
    S_PCAP = 6'b000100,
    S_SCAN = 6'b001000,
    S_ERD  = 6'b010000,
    S_EOUT = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] node_count_q;
  logic [CFG_W-1:0] rows_loaded_q, rows_loaded_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [ROW_W-1:0] pivot_q, pivot_d;

  logic [CFG_W-1:0] n_act;
  logic [ROW_W-1:0] load_mask;
  logic [ROW_W-1:0] run_mask;
  logic [ROW_W-1:0] row_m;
  logic [CNT_W-1:0] i_prev;
  logic [CNT_W-1:0] n_last;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ROW_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ROW_W-1:0]  mem_rdata;

  tce_mem #(
    .DEPTH (LIM)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Clamp the configured count to the usable range.
  always_comb begin
    n_act = node_count_q;
    if (n_act == '0) begin
      n_act = CFG_W'(1);
    end
    if (n_act > CFG_W'(LIM)) begin
      n_act = CFG_W'(LIM);
    end
  end

  assign load_mask = col_mask(n_act);
  assign run_mask  = col_mask(CFG_W'(n_q));
  assign row_m     = mem_rdata & run_mask;
  assign i_prev    = i_q - CNT_W'(1);
  assign n_last    = n_q - CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    rows_loaded_d = rows_loaded_q;
    n_d           = n_q;
    k_d           = k_q;
    i_d           = i_q;
    pivot_d       = pivot_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;

    unique case (state_q)
      S_LOAD: begin
        if (s_axis_tvalid_i) begin
          if (rows_loaded_q < CFG_W'(LIM)) begin
            mem_we    = 1'b1;
            mem_waddr = rows_loaded_q[ADDR_W-1:0];
            mem_wdata = s_axis_tdata_i & load_mask;
          end
          rows_loaded_d = rows_loaded_q + CFG_W'(1);
          if (rows_loaded_d >= n_act) begin
            rows_loaded_d = '0;
            n_d           = CNT_W'(n_act);
            k_d           = '0;
            state_d       = S_PIV;
          end
        end
      end
      S_PIV: begin
        mem_re    = 1'b1;
        mem_raddr = k_q[ADDR_W-1:0];
        state_d   = S_PCAP;
      end
      S_PCAP: begin
        // Pivot row arrives now; start streaming rows from 0.
        pivot_d   = row_m;
        mem_re    = 1'b1;
        mem_raddr = '0;
        i_d       = CNT_W'(1);
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        // Write back row i-1, merged with the pivot if it reaches node k.
        mem_we    = 1'b1;
        mem_waddr = i_prev[ADDR_W-1:0];
        mem_wdata = row_m | (row_m[5'(k_q)] ? pivot_q : '0);
        if (i_q < n_q) begin
          mem_re    = 1'b1;
          mem_raddr = i_q[ADDR_W-1:0];
          i_d       = i_q + CNT_W'(1);
        end else if (k_q == n_last) begin
          i_d     = '0;
          state_d = S_ERD;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_PIV;
        end
      end
      S_ERD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q[ADDR_W-1:0];
        state_d   = S_EOUT;
      end
      S_EOUT: begin
        if (m_axis_tready_i) begin
          if (i_q == n_last) begin
            i_d     = '0;
            state_d = S_LOAD;
          end else begin
            i_d     = i_q + CNT_W'(1);
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_LOAD;
      node_count_q  <= NODE_COUNT_RST;
      rows_loaded_q <= '0;
      n_q           <= CNT_W'(1);
      k_q           <= '0;
      i_q           <= '0;
    end else begin
      state_q       <= state_d;
      rows_loaded_q <= rows_loaded_d;
      n_q           <= n_d;
      k_q           <= k_d;
      i_q           <= i_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pivot_q <= pivot_d;
  end

  assign s_axis_tready_o = (state_q == S_LOAD);
  assign m_axis_tvalid_o = (state_q == S_EOUT);
  assign m_axis_tdata_o  = {3'b000, 5'(i_q), mem_rdata};
  assign m_axis_tlast_o  = (i_q == n_last);

endmodule

// ===== tb/transitive_closure_engine_test.sv =====
// Self-checking testbench for the transitive closure engine: graph streams against a Warshall predictor.
module transitive_closure_engine_test;
  import tce_pkg::*;

  localparam int unsigned NODES        = DEF_MAX_NODES;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 16;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [4:0]       index;
    logic             last;
  } closure_row_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             s_valid   = 1'b0;
  logic [ROW_W-1:0] s_data    = '0;
  logic             m_ready   = 1'b0;
  wire              s_ready;
  wire              m_valid;
  wire  [39:0]      m_data;
  wire              m_last;

  transitive_closure_engine #(.MAX_NODES(NODES)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: its own copy of the matrix, the load count and node_count.
  logic [ROW_W-1:0] reach_rows [NODES];
  logic [CFG_W-1:0] rows_stored    = '0;
  logic [CFG_W-1:0] node_count_reg = NODE_COUNT_RST;

  logic [ROW_W-1:0] pending_rows [$];
  closure_row_t     closure_q [$];
  closure_row_t     oldest;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_seg   = 0;
  int unsigned stall_mode  = 0;
  int unsigned hold_left   = 0;
  bit          hold_request = 1'b0;
  bit          hold_done    = 1'b0;
  bit          ready_next;

  function automatic int unsigned effective_nodes(input logic [CFG_W-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n == 0) n = 1;
    if (n > NODES) n = NODES;
    if (n > ROW_W) n = ROW_W;
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] low_mask(input int unsigned n);
    logic [ROW_W-1:0] ones;
    ones = '1;
    return ones >> (ROW_W - n);
  endfunction

  // Store one adjacency row; on the row that completes the graph, close it
  // with pivot k outermost and queue every closure row.
  task automatic predict_row(input logic [ROW_W-1:0] adj);
    int unsigned      n;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] pivot;
    closure_row_t     res;
    n    = effective_nodes(node_count_reg);
    mask = low_mask(n);
    if (rows_stored < NODES && rows_stored < ROW_W) begin
      reach_rows[rows_stored[$clog2(NODES)-1:0]] = adj & mask;
    end
    rows_stored = rows_stored + 1'b1;
    if (rows_stored >= n) begin
      for (int i = 0; i < n; i++) reach_rows[i] &= mask;
      for (int k = 0; k < n; k++) begin
        pivot = reach_rows[k];
        for (int i = 0; i < n; i++) begin
          if (reach_rows[i][k]) reach_rows[i] |= pivot;
        end
      end
      for (int i = 0; i < n; i++) begin
        res.row   = reach_rows[i] & mask;
        res.index = i[4:0];
        res.last  = (i + 1 == n);
        closure_q.push_back(res);
      end
      rows_stored = '0;
    end
  endtask

  // Driver: bursts of items with random gaps; hold data while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) predict_row(s_data);
      if (!s_valid || s_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_valid  <= 1'b0;
        end else if (pending_rows.size() != 0) begin
          s_valid <= 1'b1;
          s_data  <= pending_rows.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the result side, taken once while rows are waiting.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done && m_valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver stall pattern: segments of steady, sparse or dense readiness.
  always @(posedge clk_i) begin
    if (stall_seg == 0) begin
      stall_seg  <= $urandom_range(4, 60);
      stall_mode <= $urandom_range(0, 3);
    end else begin
      stall_seg <= stall_seg - 1;
    end
    case (stall_mode)
      0: ready_next = 1'b1;
      1: ready_next = $urandom_range(0, 1);
      2: ready_next = ($urandom_range(0, 3) == 0);
      default: ready_next = ($urandom_range(0, 7) != 0);
    endcase
    m_ready <= ready_next && (hold_left == 0);
  end

  // Monitor: compare each closure row with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (closure_q.size() == 0) begin
        $error("unexpected closure row: tdata %h, tlast %b", m_data, m_last);
        fail_count++;
      end else begin
        oldest = closure_q.pop_front();
        if (m_data[31:0] !== oldest.row) begin
          $error("closure_row: expected %h, actual %h", oldest.row, m_data[31:0]);
          fail_count++;
        end
        if (m_data[36:32] !== oldest.index) begin
          $error("row_number: expected %0d, actual %0d", oldest.index, m_data[36:32]);
          fail_count++;
        end
        if (m_last !== oldest.last) begin
          $error("final_row: expected %b, actual %b", oldest.last, m_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sample at the falling edge so the driver and monitor updates have settled.
  task automatic drain;
    while (pending_rows.size() != 0 || s_valid || closure_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_node_count(input logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we         <= 1'b0;
    node_count_reg = v;
  endtask

  // Queue rows of one graph in a random style; noise above the node count
  // is left in on purpose.
  task automatic queue_graph(input int unsigned rows, input int unsigned n);
    int unsigned      style;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] row;
    style = $urandom_range(0, 3);
    mask  = low_mask(n);
    for (int i = 0; i < rows; i++) begin
      case (style)
        0: row = $urandom;
        1: begin
          row = ROW_W'(1) << $urandom_range(0, n - 1);
          if ($urandom_range(0, 1)) row |= ROW_W'(1) << $urandom_range(0, ROW_W - 1);
        end
        2: begin
          row = ($urandom_range(0, 5) == 0) ? '0 : ROW_W'(1) << ((i + 1) % n);
          row |= $urandom & ~mask;
        end
        default: row = $urandom_range(0, 1) ? '1 : '0;
      endcase
      pending_rows.push_back(row);
    end
  endtask

  initial begin
    int unsigned      random_items;
    int unsigned      batch;
    int unsigned      graphs;
    int unsigned      n;
    int unsigned      pick;
    int unsigned      big_left;
    int unsigned      partial;
    logic [CFG_W-1:0] count;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset count: one full-size graph.
    queue_graph(NODES, NODES);
    drain();

    // Zero count acts as one node.
    set_node_count(CFG_W'(0));
    pending_rows.push_back(32'hFFFF_FFFF);
    pending_rows.push_back(32'h0000_0000);
    drain();
    set_node_count(CFG_W'(1));
    pending_rows.push_back(32'hFFFF_FFFE);
    drain();
    // Two-node cycle, then columns beyond the count.
    set_node_count(CFG_W'(2));
    pending_rows.push_back(32'h0000_0002);
    pending_rows.push_back(32'h0000_0001);
    pending_rows.push_back(32'hFFFF_FFFF);
    pending_rows.push_back(32'h0000_0000);
    drain();
    set_node_count(CFG_W'(4));
    pending_rows.push_back(32'h0000_0002);
    pending_rows.push_back(32'h0000_0004);
    pending_rows.push_back(32'h0000_0008);
    pending_rows.push_back(32'h0000_0000);
    drain();
    // Count lowered below the rows already loaded: next item closes the graph.
    set_node_count(CFG_W'(8));
    pending_rows.push_back(32'h0000_0002);
    pending_rows.push_back(32'h0000_0004);
    pending_rows.push_back(32'h0000_0001);
    drain();
    set_node_count(CFG_W'(2));
    pending_rows.push_back(32'h8000_0000);
    drain();
    // Count lowered but still above the rows loaded.
    set_node_count(CFG_W'(8));
    pending_rows.push_back(32'h0000_0006);
    pending_rows.push_back(32'h0000_0001);
    drain();
    set_node_count(CFG_W'(5));
    pending_rows.push_back(32'h0000_0008);
    pending_rows.push_back(32'h0000_0010);
    pending_rows.push_back(32'h0000_0000);
    drain();

    hold_request = 1'b1;
    random_items = 0;
    batch        = 0;
    big_left     = 2;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        count = CFG_W'(0);
      end else if (pick < 78) begin
        count = CFG_W'($urandom_range(1, 8));
      end else if (pick < 94) begin
        count = CFG_W'($urandom_range(9, 16));
      end else if (big_left != 0) begin
        count = (big_left == 2) ? CFG_W'(63) : CFG_W'($urandom_range(17, 63));
        big_left--;
      end else begin
        count = CFG_W'($urandom_range(2, 6));
      end
      set_node_count(count);
      n = effective_nodes(count);
      graphs = (batch == 0) ? 3 : (n > 8) ? 1 : $urandom_range(1, 4);
      for (int g = 0; g < graphs; g++) begin
        queue_graph(n, n);
        random_items += n;
      end
      // Leave a graph half loaded now and then; the next count takes over.
      if (n > 1 && $urandom_range(0, 4) == 0) begin
        partial = $urandom_range(1, n - 1);
        queue_graph(partial, n);
        random_items += partial;
      end
      drain();
      batch++;
    end
    // Finish any graph left half loaded.
    set_node_count(CFG_W'(1));
    pending_rows.push_back($urandom);
    drain();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
